>>> hw/rtl/sobel_gradient_magnitude_top_macros.svh
// assertion macros shared by the sobel gradient magnitude rtl
`ifndef SOBEL_GRADIENT_MAGNITUDE_TOP_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// condition implies consequence in the same cycle
`define SGM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define SGM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SGM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SGM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hw/rtl/sgm_pkg.sv
// shared constants and controller/datapath interface types for the sobel block
package sgm_pkg;

    localparam int MAX_COLS_DEF   = 2048;
    localparam int PIXEL_BITS_DEF = 12;

    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 13;
    localparam int CFG_W    = 13;
    localparam int MAG_W    = 15;
    localparam int ROW_W    = 14;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

    // register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // request commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic clear;
        logic load;
        logic calc;
        logic sq_first;
        logic sq_acc;
        logic root_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic emit;
        logic out_free;
    } t_status;

endpackage

>>> hw/rtl/sobel_gradient_magnitude_top.sv
// top level of the 3x3 sobel gradient magnitude block
//
//  channel   direction  handshake                  payload
//  config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//  pixel     in         i_in_valid / o_in_stall    i_command, i_pixel_value
//  result    out        o_out_valid / i_out_stall  o_magnitude, o_frame_last
//
// a request that yields a result occupies the block through the window step, the two
// squaring steps and the bit-serial square root, one result bit per cycle
// a request that yields no result takes only the load and window steps
// after reset the line stores are cleared, with o_in_stall high throughout
// a finished result waits in the output register; the next request is accepted meanwhile
module sobel_gradient_magnitude_top #(
    parameter int MAX_COLS   = sgm_pkg::MAX_COLS_DEF,
    parameter int PIXEL_BITS = sgm_pkg::PIXEL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [sgm_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_command,
    input  logic [PIXEL_BITS-1:0]       i_pixel_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [sgm_pkg::MAG_W-1:0]   o_magnitude,
    output logic                        o_frame_last
);

    sgm_pkg::t_cmd    cmd;
    sgm_pkg::t_status status;

    sgm_ctrl #(
        .STEPS (PIXEL_BITS + 3)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sgm_datapath #(
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_command     (i_command),
        .i_pixel_value (i_pixel_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_magnitude   (o_magnitude),
        .o_frame_last  (o_frame_last)
    );

endmodule

>>> hw/rtl/sgm_datapath.sv
// sobel datapath: line stores, window, position counters, squarer and square-root unit
module sgm_datapath #(
    parameter int MAX_COLS   = sgm_pkg::MAX_COLS_DEF,
    parameter int PIXEL_BITS = sgm_pkg::PIXEL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sgm_pkg::t_cmd               i_cmd,
    output sgm_pkg::t_status            o_status,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [sgm_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_command,
    input  logic [PIXEL_BITS-1:0]       i_pixel_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [sgm_pkg::MAG_W-1:0]   o_magnitude,
    output logic                        o_frame_last
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CW1    = $clog2(MAX_COLS + 1);
    localparam int ROW_W  = sgm_pkg::ROW_W;
    localparam int WD_W   = sgm_pkg::WIDTH_W;
    localparam int HT_W   = sgm_pkg::HEIGHT_W;
    localparam int TOT_W  = CW1 + HT_W;
    localparam int G_W    = PIXEL_BITS + 3;
    localparam int R_W    = PIXEL_BITS + 3;
    localparam int RAD_W  = 2 * R_W;
    localparam int REM_W  = R_W + 2;
    localparam int SH_W   = REM_W + 2;
    localparam int MAG_W  = sgm_pkg::MAG_W;

    // configuration
    logic [WD_W-1:0]        r_cfg_width;
    logic [HT_W-1:0]        r_cfg_height;
    logic [CW1-1:0]         w_eff;
    logic [HT_W-1:0]        h_eff;
    logic [TOT_W-1:0]       r_total;

    // line stores
    logic [PIXEL_BITS-1:0]  mem_upper [MAX_COLS];
    logic [PIXEL_BITS-1:0]  mem_lower [MAX_COLS];
    logic [COL_W-1:0]       r_clr_addr;
    logic [PIXEL_BITS-1:0]  r_top;
    logic [PIXEL_BITS-1:0]  r_mid;
    logic [PIXEL_BITS-1:0]  r_pix;

    // position and window
    logic [COL_W-1:0]       r_col;
    logic [ROW_W-1:0]       r_row;
    logic [TOT_W-1:0]       r_cnt;
    logic                   r_go;
    logic [PIXEL_BITS-1:0]  r_win [6];
    logic                   wrap;
    logic [COL_W-1:0]       ic_w;
    logic [ROW_W-1:0]       iy_w;
    logic                   go_w;

    logic                   ic_zero;
    logic                   emit;
    logic                   ox_zero;
    logic                   oy_zero;
    logic [PIXEL_BITS-1:0]  p [3][3];
    logic [G_W-1:0]         gx_pos;
    logic [G_W-1:0]         gx_neg;
    logic [G_W-1:0]         gy_pos;
    logic [G_W-1:0]         gy_neg;
    logic [CW1-1:0]         nxt_col;
    logic [TOT_W-1:0]       cnt_inc;
    logic                   last;
    logic                   r_last;

    // magnitude
    logic signed [G_W-1:0]  r_gx;
    logic signed [G_W-1:0]  r_gy;
    logic signed [G_W-1:0]  sq_op;
    logic signed [RAD_W-1:0] sq_s;
    logic [RAD_W-1:0]       sq;
    logic [RAD_W-1:0]       r_rad;
    logic [R_W-1:0]         r_root;
    logic [REM_W-1:0]       r_rem;
    logic [SH_W-1:0]        rem_sh;
    logic [SH_W-1:0]        trial;
    logic                   take;
    logic                   round_up;
    logic [R_W:0]           mag_full;

    logic                   r_out_valid;
    logic [MAG_W-1:0]       r_mag;
    logic                   r_flast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= sgm_pkg::WIDTH_RST;
            r_cfg_height <= sgm_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sgm_pkg::CFG_WIDTH:  r_cfg_width  <= i_cfg_data[WD_W-1:0];
                sgm_pkg::CFG_HEIGHT: r_cfg_height <= i_cfg_data[HT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = CW1'(1);
        end else if (32'(r_cfg_width) > 32'(MAX_COLS)) begin
            w_eff = CW1'(MAX_COLS);
        end else begin
            w_eff = CW1'(r_cfg_width);
        end
        h_eff = (r_cfg_height == '0) ? HT_W'(1) : r_cfg_height;
    end

    always_ff @(posedge i_clk) begin
        r_total <= TOT_W'(w_eff) * TOT_W'(h_eff);
    end

    // position wrap happens on every request, even one that is then dropped
    always_comb begin
        wrap = CW1'(r_col) >= w_eff;
        ic_w = wrap ? '0 : r_col;
        iy_w = wrap ? r_row + ROW_W'(1) : r_row;
        if (i_command == sgm_pkg::CMD_FLUSH) begin
            go_w = iy_w >= ROW_W'(h_eff);
        end else begin
            go_w = iy_w < ROW_W'(h_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem_upper[r_clr_addr] <= '0;
            mem_lower[r_clr_addr] <= '0;
        end else if (i_cmd.calc && r_go) begin
            mem_upper[r_col] <= r_mid;
            mem_lower[r_col] <= r_pix;
        end
        if (i_cmd.load) begin
            r_top <= mem_upper[ic_w];
            r_mid <= mem_lower[ic_w];
            r_pix <= (i_command == sgm_pkg::CMD_FLUSH) ? '0 : i_pixel_value;
        end
    end

    // window assembly with out-of-image neighbours forced to zero
    always_comb begin
        ic_zero = r_col == '0;
        emit    = r_go && (ic_zero ? (r_row >= ROW_W'(2)) : (r_row >= ROW_W'(1)));
        ox_zero = ic_zero ? (w_eff == CW1'(1)) : (r_col == COL_W'(1));
        oy_zero = ic_zero ? (r_row == ROW_W'(2)) : (r_row == ROW_W'(1));
        for (int r = 0; r < 3; r++) begin
            p[r][0] = ox_zero ? '0 : r_win[r];
            p[r][1] = r_win[3+r];
        end
        p[0][2] = ic_zero ? '0 : r_top;
        p[1][2] = ic_zero ? '0 : r_mid;
        p[2][2] = ic_zero ? '0 : r_pix;
        if (oy_zero) begin
            p[0][0] = '0;
            p[0][1] = '0;
            p[0][2] = '0;
        end
        gx_pos = G_W'(p[0][2]) + (G_W'(p[1][2]) << 1) + G_W'(p[2][2]);
        gx_neg = G_W'(p[0][0]) + (G_W'(p[1][0]) << 1) + G_W'(p[2][0]);
        gy_pos = G_W'(p[2][0]) + (G_W'(p[2][1]) << 1) + G_W'(p[2][2]);
        gy_neg = G_W'(p[0][0]) + (G_W'(p[0][1]) << 1) + G_W'(p[0][2]);
        nxt_col = CW1'(r_col) + CW1'(1);
        cnt_inc = r_cnt + TOT_W'(1);
        last    = cnt_inc >= r_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_cnt <= '0;
            r_go  <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_cmd.load) begin
            r_col <= ic_w;
            r_row <= iy_w;
            r_go  <= go_w;
        end else if (i_cmd.calc && r_go) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= r_top;
            r_win[4] <= r_mid;
            r_win[5] <= r_pix;
            if (emit && last) begin
                r_col <= '0;
                r_row <= '0;
                r_cnt <= '0;
            end else begin
                if (nxt_col >= w_eff) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_W'(1);
                end else begin
                    r_col <= COL_W'(nxt_col);
                end
                if (emit) begin
                    r_cnt <= cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_gx   <= $signed(gx_pos - gx_neg);
            r_gy   <= $signed(gy_pos - gy_neg);
            r_last <= last;
        end
    end

    // one shared squarer: gx first, then gy accumulated
    assign sq_op = i_cmd.sq_first ? r_gx : r_gy;
    assign sq_s  = RAD_W'(sq_op) * RAD_W'(sq_op);
    assign sq    = $unsigned(sq_s);

    // restoring square root, one result bit per step
    always_comb begin
        rem_sh   = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial    = SH_W'({r_root, 2'b01});
        take     = rem_sh >= trial;
        round_up = REM_W'(r_root) < r_rem;
        mag_full = (R_W+1)'(r_root) + (R_W+1)'(round_up);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_first) begin
            r_rad  <= sq;
            r_root <= '0;
            r_rem  <= '0;
        end else if (i_cmd.sq_acc) begin
            r_rad <= r_rad + sq;
        end else if (i_cmd.root_step) begin
            r_rad  <= r_rad << 2;
            r_root <= {r_root[R_W-2:0], take};
            r_rem  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_mag   <= MAG_W'(mag_full);
            r_flast <= r_last;
        end
    end

    assign o_status.clear_done = r_clr_addr == COL_W'(MAX_COLS - 1);
    assign o_status.emit       = emit;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_magnitude  = r_mag;
    assign o_frame_last = r_flast;

endmodule

>>> hw/rtl/sgm_ctrl.sv
// sobel controller: clearing pass, request sequencing and square-root step count
`include "sobel_gradient_magnitude_top_macros.svh"

module sgm_ctrl #(
    parameter int STEPS = sgm_pkg::PIXEL_BITS_DEF + 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sgm_pkg::t_status   i_status,
    output sgm_pkg::t_cmd      o_cmd
);

    localparam int STEP_W = $clog2(STEPS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_SQX   = 3'd3;
    localparam logic [2:0] S_SQY   = 3'd4;
    localparam logic [2:0] S_ROOT  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = i_status.emit ? S_SQX : S_IDLE;
            end
            S_SQX: begin
                o_cmd.sq_first = 1'b1;
                n_state        = S_SQY;
            end
            S_SQY: begin
                o_cmd.sq_acc = 1'b1;
                n_step       = '0;
                n_state      = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

    `SGM_ASSERT_NEXT(a_load_then_calc, i_clk, i_rst_n, o_cmd.load, r_state == S_CALC,
        "accepted request not followed by window calculation")
    `SGM_ASSERT_NOW(a_out_only_when_free, i_clk, i_rst_n, o_cmd.out_load, i_status.out_free,
        "result loaded while output register still held")
    `SGM_ASSERT_NOW(a_no_load_in_clear, i_clk, i_rst_n, o_cmd.clear, !o_cmd.load,
        "request accepted during line store clearing")
    `SGM_ASSERT_NEXT(a_root_to_out, i_clk, i_rst_n,
        (r_state == S_ROOT) && (r_step == STEP_W'(STEPS - 1)), r_state == S_OUT,
        "square root did not finish after its last step")

endmodule

>>> dv/sobel_gradient_magnitude_top_test.sv
// testbench for the sobel gradient magnitude block: random frames, predicted magnitudes checked in order
`timescale 1ns / 100ps

typedef struct {
    logic [sgm_pkg::MAG_W-1:0] magnitude;
    logic                      frame_last;
} t_gradient_result;

typedef enum int {
    PAT_RANDOM,
    PAT_BINARY,
    PAT_CHECKER,
    PAT_FULL
} t_pixel_pattern;

class edge_magnitude_board;
    localparam int COLS = sgm_pkg::MAX_COLS_DEF;
    localparam int PIX  = sgm_pkg::PIXEL_BITS_DEF;

    logic [sgm_pkg::WIDTH_W-1:0]  width_reg;
    logic [sgm_pkg::HEIGHT_W-1:0] height_reg;
    logic [PIX-1:0]               upper_line [COLS];
    logic [PIX-1:0]               lower_line [COLS];
    logic [PIX-1:0]               window [6];
    int unsigned                  col;
    int unsigned                  row;
    int unsigned                  emitted;
    t_gradient_result             pending_gradients [$];
    int                           fails;

    function new();
        foreach (upper_line[i]) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        foreach (window[i]) window[i] = '0;
        col        = 0;
        row        = 0;
        emitted    = 0;
        fails      = 0;
        width_reg  = sgm_pkg::WIDTH_RST;
        height_reg = sgm_pkg::HEIGHT_RST;
    endfunction

    function void set_geometry(logic [sgm_pkg::WIDTH_W-1:0] w, logic [sgm_pkg::HEIGHT_W-1:0] h);
        width_reg  = w;
        height_reg = h;
    endfunction

    function int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > COLS) return COLS;
        return width_reg;
    endfunction

    function int unsigned eff_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int outstanding();
        return pending_gradients.size();
    endfunction

    // every pixel of the frame has gone in, only flush requests move it on
    function bit pixels_done();
        int unsigned r;
        r = (col >= eff_width()) ? row + 1 : row;
        return r >= eff_height();
    endfunction

    function bit frame_open();
        return col != 0 || row != 0 || emitted != 0;
    endfunction

    function logic [sgm_pkg::MAG_W-1:0] predict_gradient(int gx, int gy);
        longint unsigned n;
        longint unsigned r;
        longint unsigned t;
        n = longint'(gx) * gx + longint'(gy) * gy;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= n) r = t;
        end
        // round to nearest, an exact half cannot occur
        if (n - r * r > r) r++;
        return r[sgm_pkg::MAG_W-1:0];
    endfunction

    // returns 0 when the block ignores the request
    function bit note_pixel_request(logic cmd, logic [PIX-1:0] pix);
        int unsigned      w;
        int unsigned      h;
        int unsigned      ic;
        int unsigned      iy;
        int unsigned      ox;
        int unsigned      oy;
        logic [PIX-1:0]   v;
        logic [PIX-1:0]   top;
        logic [PIX-1:0]   mid;
        bit               emit;
        bit               last;
        int               p [3][3];
        int               gx;
        int               gy;
        t_gradient_result res;

        w = eff_width();
        h = eff_height();
        if (col >= w) begin
            col = 0;
            row++;
        end
        if (cmd == sgm_pkg::CMD_PIXEL && row >= h) return 0;
        if (cmd == sgm_pkg::CMD_FLUSH && row < h) return 0;

        v   = (cmd == sgm_pkg::CMD_FLUSH) ? '0 : pix;
        ic  = col;
        iy  = row;
        top = upper_line[ic];
        mid = lower_line[ic];
        upper_line[ic] = mid;
        lower_line[ic] = v;

        // column zero closes the last pixel of the row above
        if (ic == 0) begin
            emit = iy >= 2;
            ox   = w - 1;
            oy   = iy - 2;
        end else begin
            emit = iy >= 1;
            ox   = ic - 1;
            oy   = iy - 1;
        end

        if (emit) begin
            for (int r = 0; r < 3; r++) begin
                p[r][0] = (ox == 0) ? 0 : int'(window[r]);
                p[r][1] = int'(window[3 + r]);
            end
            p[0][2] = (ic == 0) ? 0 : int'(top);
            p[1][2] = (ic == 0) ? 0 : int'(mid);
            p[2][2] = (ic == 0) ? 0 : int'(v);
            if (oy == 0) begin
                p[0][0] = 0;
                p[0][1] = 0;
                p[0][2] = 0;
            end
        end

        window[0] = window[3];
        window[1] = window[4];
        window[2] = window[5];
        window[3] = top;
        window[4] = mid;
        window[5] = v;

        col = ic + 1;
        if (col >= w) begin
            col = 0;
            row = iy + 1;
        end

        if (emit) begin
            gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
            gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
            if (gx < 0) gx = -gx;
            if (gy < 0) gy = -gy;
            last = longint'(emitted) + 1 >= longint'(w) * h;
            res.magnitude  = predict_gradient(gx, gy);
            res.frame_last = last;
            pending_gradients.push_back(res);
            emitted++;
            if (last) begin
                col     = 0;
                row     = 0;
                emitted = 0;
            end
        end
        return 1;
    endfunction

    task report_mismatch(string what);
        if (fails < 100) $display("mismatch: %s", what);
        fails++;
    endtask

    task check_magnitude(logic [sgm_pkg::MAG_W-1:0] mag, logic last);
        t_gradient_result want;
        if (pending_gradients.size() == 0) begin
            report_mismatch($sformatf("result %0d with no request waiting", mag));
            return;
        end
        want = pending_gradients.pop_front();
        if (mag !== want.magnitude)
            report_mismatch($sformatf("magnitude %0d, expected %0d", mag, want.magnitude));
        if (last !== want.frame_last)
            report_mismatch($sformatf("frame_last %b, expected %b (magnitude %0d)",
                                      last, want.frame_last, want.magnitude));
    endtask
endclass

module sobel_gradient_magnitude_top_test;

    localparam int PIX_W          = sgm_pkg::PIXEL_BITS_DEF;
    localparam int CFG_W          = sgm_pkg::CFG_W;
    localparam int MAG_W          = sgm_pkg::MAG_W;
    localparam int WIDTH_W        = sgm_pkg::WIDTH_W;
    localparam int HEIGHT_W       = sgm_pkg::HEIGHT_W;
    localparam int SETTLE_CYCLES  = 2 * (PIX_W + 8) + 4;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 300;
    localparam int RANDOM_ITEMS   = 550;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic                 i_cfg_index    = sgm_pkg::CFG_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic                 i_command      = sgm_pkg::CMD_PIXEL;
    logic [PIX_W-1:0]     i_pixel_value  = '0;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic [MAG_W-1:0]     o_magnitude;
    logic                 o_frame_last;

    edge_magnitude_board sb;
    int  send_idle_pct = 0;
    int  stall_pct     = 0;
    bit  long_hold_req = 1'b0;
    int  hold_left     = 0;
    int  quiet_cycles  = 0;
    int  live_items    = 0;

    sobel_gradient_magnitude_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_pixel_value (i_pixel_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_magnitude   (o_magnitude),
        .o_frame_last  (o_frame_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver: random stalls, or one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_magnitude(o_magnitude, o_frame_last);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0)
                || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(logic cmd, logic [PIX_W-1:0] pix);
        int gap;
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_pixel_value <= pix;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (sb.note_pixel_request(cmd, pix)) live_items++;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sender pauses until every predicted result is in, then the block runs dry
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(logic [WIDTH_W-1:0] w, logic [HEIGHT_W-1:0] h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sgm_pkg::CFG_WIDTH;
        i_cfg_data  <= CFG_W'(w);
        @(posedge i_clk);
        i_cfg_index <= sgm_pkg::CFG_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_geometry(w, h);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(t_pixel_pattern pat, int idx);
        case (pat)
            PAT_BINARY:  return $urandom_range(1) ? '1 : '0;
            PAT_CHECKER: return idx[0] ? '1 : '0;
            PAT_FULL:    return '1;
            default:     return PIX_W'($urandom);
        endcase
    endfunction

    // pixels until the frame is in, then flush ticks until the final result is predicted
    task automatic stream_frame(t_pixel_pattern pat, int noise_pct);
        int idx;
        idx = 0;
        while (!sb.pixels_done()) begin
            if ($urandom_range(99) < noise_pct) begin
                send_request(sgm_pkg::CMD_FLUSH, PIX_W'($urandom));
            end else begin
                send_request(sgm_pkg::CMD_PIXEL, pick_pixel(pat, idx));
                idx++;
            end
        end
        while (sb.frame_open()) begin
            if ($urandom_range(99) < noise_pct)
                send_request(sgm_pkg::CMD_PIXEL, PIX_W'($urandom));
            else
                send_request(sgm_pkg::CMD_FLUSH, PIX_W'($urandom));
        end
    endtask

    initial begin
        int phase;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero width and height act as a one pixel frame, with stray requests mixed in
        configure('0, '0);
        send_request(sgm_pkg::CMD_FLUSH, 12'hABC);
        send_request(sgm_pkg::CMD_PIXEL, 12'hFFF);
        send_request(sgm_pkg::CMD_PIXEL, 12'h5A5);
        send_request(sgm_pkg::CMD_FLUSH, 12'h000);
        send_request(sgm_pkg::CMD_FLUSH, 12'h000);
        settle_block();

        configure(12'd3, 13'd3);
        stream_frame(PAT_CHECKER, 0);
        settle_block();

        // oversized geometry, then shrunk mid-frame so the column wraps
        configure(12'hFFF, 13'h1FFF);
        repeat (4) send_request(sgm_pkg::CMD_PIXEL, pick_pixel(PAT_RANDOM, 0));
        settle_block();
        configure(12'd3, 13'd2);
        stream_frame(PAT_RANDOM, 0);
        settle_block();

        live_items = 0;
        phase = 0;
        while (live_items < RANDOM_ITEMS) begin
            case (phase % 5)
                1: begin send_idle_pct = 74; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 74; end
                3: begin send_idle_pct = 16; stall_pct = 16; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            settle_block();
            if (phase == 5) begin
                // block fills up behind a long receiver hold-off
                configure(12'd10, 13'd6);
                long_hold_req = 1'b1;
            end else begin
                configure(($urandom_range(9) == 0) ? 12'd0 : 12'($urandom_range(1, 12)),
                          ($urandom_range(9) == 0) ? 13'd0 : 13'($urandom_range(1, 8)));
            end
            stream_frame(t_pixel_pattern'($urandom_range(3)), 5);
            phase++;
        end
        settle_block();

        if (sb.fails == 0 && sb.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
